// ----- design/dens_pkg.sv -----
`default_nettype none

package dens_pkg;

    // Command codes carried in the input word
    localparam logic [1:0] CMD_NEW_SEARCH = 2'd0;
    localparam logic [1:0] CMD_NAME_BYTE  = 2'd1;
    localparam logic [1:0] CMD_DIR_BYTE   = 2'd2;

    // Status codes carried in the result word
    localparam logic [1:0] ST_SEARCHING = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_ABANDONED = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    // Directory entry header layout
    localparam int unsigned HDR_BYTES      = 8;
    localparam logic [1:0]  REC_ALIGN_MASK = 2'd3;
    localparam int unsigned NAME_LIMIT     = 255;

    // Input word
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic        first_in_block;
        logic [12:0] block_bytes;
    } item_t;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] inode_number;
    } result_t;

endpackage

`default_nettype wire

// ----- design/dens_name_ram.sv -----
`default_nettype none

// Target name store: one write port, one registered read port.
// A read of the address written in the same cycle returns the new byte.
module dens_name_ram #(
    parameter int unsigned DEPTH = 255,
    parameter int unsigned AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] name_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_mem[wr_addr] <= wr_data;
        end
    end

    // Read port with write-through bypass
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= name_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/directory_entry_name_search.sv -----
`default_nettype none

// Channel   Handshake                  Word              Direction
// item      item_valid / item_ready    dens_pkg::item_t     in
// result    result_valid / result_ready dens_pkg::result_t out
//
// One result word per accepted item, valid in the cycle after acceptance.
// One item per cycle while result_ready is high; the header parse, name compare and
// status are one pass of logic between the parse registers and the result register.
// The name byte for the next compare is read ahead from the name store each cycle.
// Reset (rst_n low, asynchronous) clears all parse and search state.
// item_ready drops only while a result word waits and result_ready is low.
module directory_entry_name_search #(
    parameter int unsigned NAME_MAX_BYTES  = 255,
    parameter int unsigned BLOCK_MAX_BYTES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire dens_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output dens_pkg::result_t      result
);

    localparam int unsigned OW  = $clog2(BLOCK_MAX_BYTES + 1);
    localparam int unsigned TLW = $clog2(NAME_MAX_BYTES + 1);
    localparam int unsigned AW  = (NAME_MAX_BYTES > 1) ? $clog2(NAME_MAX_BYTES) : 1;
    localparam logic [12:0]    BLOCK_MAX_W = 13'(BLOCK_MAX_BYTES);
    localparam logic [TLW-1:0] NAME_MAX_TL = TLW'(NAME_MAX_BYTES);
    localparam logic [OW-1:0]  HDR_OW      = OW'(dens_pkg::HDR_BYTES);

    // Search and parse state
    logic [TLW-1:0] target_length_reg, target_length_next;
    logic           name_overflow_reg, name_overflow_next;
    logic [OW-1:0]  block_offset_reg, block_offset_next;
    logic [OW-1:0]  entry_start_reg, entry_start_next;
    logic [31:0]    entry_inode_reg, entry_inode_next;
    logic [15:0]    record_length_reg, record_length_next;
    logic [7:0]     entry_name_length_reg, entry_name_length_next;
    logic           names_agree_reg, names_agree_next;
    logic           block_abandoned_reg, block_abandoned_next;
    logic           match_found_reg, match_found_next;
    logic [31:0]    found_inode_reg, found_inode_next;

    // Output register
    logic              result_valid_reg;
    dens_pkg::result_t result_reg, result_next;

    // Name store port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [OW-1:0] k_ahead;

    // Per-byte working values
    logic          item_accept;
    logic          restart;
    logic [OW-1:0] valid_sat;
    logic [OW-1:0] eff_offset;
    logic [OW-1:0] eff_start;
    logic [31:0]   eff_inode;
    logic [15:0]   eff_rlen;
    logic [7:0]    eff_nlen;
    logic          eff_agree;
    logic          eff_abandoned;
    logic [OW-1:0] rel;
    logic [OW-1:0] name_idx;
    logic          take_byte;
    logic          bad_entry;
    logic          agree_now;
    logic          advance;
    logic [1:0]    status_next;

    assign item_accept = item_valid && item_ready;
    assign item_ready  = !result_valid_reg || result_ready;

    // Saturated block byte count
    assign valid_sat = (item.block_bytes > BLOCK_MAX_W) ? BLOCK_MAX_W[OW-1:0]
                                                       : item.block_bytes[OW-1:0];

    // Parse state seen by this byte: a block start clears it first
    assign restart       = item_accept && (item.command == dens_pkg::CMD_DIR_BYTE)
                           && item.first_in_block;
    assign eff_offset    = restart ? '0 : block_offset_reg;
    assign eff_start     = restart ? '0 : entry_start_reg;
    assign eff_inode     = restart ? '0 : entry_inode_reg;
    assign eff_rlen      = restart ? '0 : record_length_reg;
    assign eff_nlen      = restart ? '0 : entry_name_length_reg;
    assign eff_agree     = restart ? 1'b1 : names_agree_reg;
    assign eff_abandoned = restart ? 1'b0 : block_abandoned_reg;

    assign rel      = eff_offset - eff_start;
    assign name_idx = rel - HDR_OW;

    assign take_byte = !match_found_reg && !name_overflow_reg && !eff_abandoned
                       && (eff_offset < valid_sat);

    // Header check on the last header byte
    assign bad_entry = (eff_rlen < 16'(dens_pkg::HDR_BYTES))
                       || ((eff_rlen[1:0] & dens_pkg::REC_ALIGN_MASK) != 2'd0)
                       || ((17'(eff_start) + 17'(eff_rlen)) > 17'(valid_sat))
                       || (16'(eff_nlen) > (eff_rlen - 16'(dens_pkg::HDR_BYTES)));

    // Name byte compare against the prefetched target byte
    assign agree_now = eff_agree && (32'(name_idx) < 32'(target_length_reg))
                       && (rd_data == item.data_byte);

    // Next state
    always_comb
    begin
        target_length_next     = target_length_reg;
        name_overflow_next     = name_overflow_reg;
        block_offset_next      = block_offset_reg;
        entry_start_next       = entry_start_reg;
        entry_inode_next       = entry_inode_reg;
        record_length_next     = record_length_reg;
        entry_name_length_next = entry_name_length_reg;
        names_agree_next       = names_agree_reg;
        block_abandoned_next   = block_abandoned_reg;
        match_found_next       = match_found_reg;
        found_inode_next       = found_inode_reg;
        wr_en                  = 1'b0;
        advance                = 1'b0;

        if (item_accept)
        begin
            case (item.command)
                dens_pkg::CMD_NEW_SEARCH:
                begin
                    target_length_next     = '0;
                    name_overflow_next     = 1'b0;
                    match_found_next       = 1'b0;
                    found_inode_next       = '0;
                    block_offset_next      = '0;
                    entry_start_next       = '0;
                    entry_inode_next       = '0;
                    record_length_next     = '0;
                    entry_name_length_next = '0;
                    names_agree_next       = 1'b1;
                    block_abandoned_next   = 1'b0;
                end
                dens_pkg::CMD_NAME_BYTE:
                begin
                    if (target_length_reg < NAME_MAX_TL)
                    begin
                        wr_en              = 1'b1;
                        target_length_next = target_length_reg + 1'b1;
                    end
                    else
                    begin
                        name_overflow_next = 1'b1;
                    end
                end
                dens_pkg::CMD_DIR_BYTE:
                begin
                    block_offset_next      = eff_offset;
                    entry_start_next       = eff_start;
                    entry_inode_next       = eff_inode;
                    record_length_next     = eff_rlen;
                    entry_name_length_next = eff_nlen;
                    names_agree_next       = eff_agree;
                    block_abandoned_next   = eff_abandoned;
                    if (take_byte)
                    begin
                        advance = 1'b1;
                        if (rel < OW'(4))
                        begin
                            if (rel == '0)
                            begin
                                entry_inode_next = '0;
                            end
                            entry_inode_next[{rel[1:0], 3'b000} +: 8] = item.data_byte;
                        end
                        else if (rel == OW'(4))
                        begin
                            record_length_next = {8'd0, item.data_byte};
                        end
                        else if (rel == OW'(5))
                        begin
                            record_length_next = eff_rlen | {item.data_byte, 8'd0};
                        end
                        else if (rel == OW'(6))
                        begin
                            entry_name_length_next = item.data_byte;
                            names_agree_next       = 1'b1;
                        end
                        else if (rel == OW'(7))
                        begin
                            if (bad_entry)
                            begin
                                block_abandoned_next = 1'b1;
                                advance              = 1'b0;
                            end
                            else if ((eff_nlen == 8'd0) && (eff_inode != '0)
                                     && (target_length_reg == '0) && eff_agree)
                            begin
                                match_found_next = 1'b1;
                                found_inode_next = eff_inode;
                                advance          = 1'b0;
                            end
                        end
                        else if (32'(name_idx) < 32'(eff_nlen))
                        begin
                            names_agree_next = agree_now;
                            if (((32'(name_idx) + 32'd1) == 32'(eff_nlen))
                                && (eff_inode != '0)
                                && (32'(eff_nlen) == 32'(target_length_reg))
                                && agree_now)
                            begin
                                match_found_next = 1'b1;
                                found_inode_next = eff_inode;
                                advance          = 1'b0;
                            end
                        end

                        // Step to the next byte, and to the next entry at its end
                        if (advance)
                        begin
                            if ((rel >= OW'(7)) && ((16'(rel) + 16'd1) == record_length_next))
                            begin
                                entry_start_next = eff_start + record_length_next[OW-1:0];
                                names_agree_next = 1'b1;
                            end
                            block_offset_next = eff_offset + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result word from the updated state
    always_comb
    begin
        if (name_overflow_next)
        begin
            status_next = dens_pkg::ST_TOO_LONG;
        end
        else if (match_found_next)
        begin
            status_next = dens_pkg::ST_FOUND;
        end
        else if (block_abandoned_next)
        begin
            status_next = dens_pkg::ST_ABANDONED;
        end
        else
        begin
            status_next = dens_pkg::ST_SEARCHING;
        end
        result_next.status       = status_next;
        result_next.inode_number = (status_next == dens_pkg::ST_FOUND) ? found_inode_next
                                                                       : 32'd0;
    end

    // Name store addressing: prefetch the byte the next directory byte compares with
    assign wr_addr = target_length_reg[AW-1:0];
    assign k_ahead = block_offset_next - entry_start_next - HDR_OW;
    assign rd_addr = (32'(k_ahead) < NAME_MAX_BYTES) ? k_ahead[AW-1:0] : '0;

    dens_name_ram #(
        .DEPTH (NAME_MAX_BYTES),
        .AW    (AW)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_length_reg     <= '0;
            name_overflow_reg     <= 1'b0;
            block_offset_reg      <= '0;
            entry_start_reg       <= '0;
            entry_inode_reg       <= '0;
            record_length_reg     <= '0;
            entry_name_length_reg <= '0;
            names_agree_reg       <= 1'b1;
            block_abandoned_reg   <= 1'b0;
            match_found_reg       <= 1'b0;
            found_inode_reg       <= '0;
        end
        else
        begin
            target_length_reg     <= target_length_next;
            name_overflow_reg     <= name_overflow_next;
            block_offset_reg      <= block_offset_next;
            entry_start_reg       <= entry_start_next;
            entry_inode_reg       <= entry_inode_next;
            record_length_reg     <= record_length_next;
            entry_name_length_reg <= entry_name_length_next;
            names_agree_reg       <= names_agree_next;
            block_abandoned_reg   <= block_abandoned_next;
            match_found_reg       <= match_found_next;
            found_inode_reg       <= found_inode_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // Found status always carries a live inode, other statuses carry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == dens_pkg::ST_FOUND) |-> result.inode_number != 32'd0)
        else $error("found status with zero inode");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != dens_pkg::ST_FOUND) |-> result.inode_number == 32'd0)
        else $error("inode reported without a match");

    // Entry start never runs past the parse offset, which stays in the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (entry_start_reg <= block_offset_reg) && (32'(block_offset_reg) <= BLOCK_MAX_BYTES))
        else $error("parse offsets out of order");

    // Overflow holds until a new search is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        name_overflow_reg && !(item_accept && (item.command == dens_pkg::CMD_NEW_SEARCH))
        |=> name_overflow_reg)
        else $error("name overflow cleared without a new search");

    // Target never holds more than the name limit
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(target_length_reg) <= NAME_MAX_BYTES)
        else $error("target length past limit");
`endif

endmodule

`default_nettype wire

// ----- tb/directory_entry_name_search_tb.sv -----
`timescale 1ns / 1ps

module directory_entry_name_search_tb;

    localparam int unsigned NAME_MAX_BYTES  = 255;
    localparam int unsigned BLOCK_MAX_BYTES = 4096;
    localparam int unsigned ITEM_GOAL       = 600;
    localparam logic [1:0]  CMD_NONE        = 2'd3;

    // Tracks the search state, predicts one result word per accepted item and
    // checks result words in order against those predictions.
    class lookup_tracker;
        logic [7:0]  target_bytes [dens_pkg::NAME_LIMIT];
        int unsigned target_len;
        bit          name_too_long;
        bit          found;
        logic [31:0] found_inode;

        // Per-block parse state
        int unsigned offset;
        int unsigned entry_base;
        logic [31:0] entry_inode;
        int unsigned rec_len;
        int unsigned entry_name_bytes;
        bit          names_equal;
        bit          abandoned;

        dens_pkg::result_t due_outcomes [$];
        int unsigned errors;
        int unsigned seen_words;

        function new();
            target_len = 0;
            name_too_long = 1'b0;
            found = 1'b0;
            found_inode = '0;
            errors = 0;
            seen_words = 0;
            restart_block();
        endfunction

        function void restart_block();
            offset = 0;
            entry_base = 0;
            entry_inode = '0;
            rec_len = 0;
            entry_name_bytes = 0;
            names_equal = 1'b1;
            abandoned = 1'b0;
        endfunction

        function void settle_match();
            if (entry_inode != 0 && entry_name_bytes == target_len && names_equal)
            begin
                found = 1'b1;
                found_inode = entry_inode;
            end
        endfunction

        // Advance the search by one accepted word and queue the outcome it yields
        function void note_item(dens_pkg::item_t w);
            int unsigned       limit;
            int unsigned       rel;
            int unsigned       k;
            dens_pkg::result_t outcome;
            seen_words++;
            limit = (w.block_bytes > BLOCK_MAX_BYTES) ? BLOCK_MAX_BYTES : w.block_bytes;
            case (w.command)
                dens_pkg::CMD_NEW_SEARCH:
                begin
                    target_len = 0;
                    name_too_long = 1'b0;
                    found = 1'b0;
                    found_inode = '0;
                    restart_block();
                end
                dens_pkg::CMD_NAME_BYTE:
                begin
                    if (target_len < NAME_MAX_BYTES)
                    begin
                        target_bytes[target_len] = w.data_byte;
                        target_len++;
                    end
                    else
                    begin
                        name_too_long = 1'b1;
                    end
                end
                dens_pkg::CMD_DIR_BYTE:
                begin
                    if (w.first_in_block)
                        restart_block();
                    if (!(found || name_too_long || abandoned) && offset < limit)
                    begin
                        rel = offset - entry_base;
                        if (rel < 4)
                        begin
                            if (rel == 0)
                                entry_inode = '0;
                            entry_inode |= 32'(w.data_byte) << (8 * rel);
                        end
                        else if (rel == 4)
                        begin
                            rec_len = w.data_byte;
                        end
                        else if (rel == 5)
                        begin
                            rec_len |= 32'(w.data_byte) << 8;
                        end
                        else if (rel == 6)
                        begin
                            entry_name_bytes = w.data_byte;
                            names_equal = 1'b1;
                        end
                        else if (rel == 7)
                        begin
                            // header complete: validate record and name lengths
                            if (rec_len < dens_pkg::HDR_BYTES ||
                                (rec_len & dens_pkg::REC_ALIGN_MASK) != 0 ||
                                entry_base + rec_len > limit ||
                                entry_name_bytes > rec_len - dens_pkg::HDR_BYTES)
                                abandoned = 1'b1;
                            else if (entry_name_bytes == 0)
                                settle_match();
                        end
                        else
                        begin
                            k = rel - dens_pkg::HDR_BYTES;
                            if (k < entry_name_bytes)
                            begin
                                if (k >= target_len || target_bytes[k] != w.data_byte)
                                    names_equal = 1'b0;
                                if (k + 1 == entry_name_bytes)
                                    settle_match();
                            end
                        end
                        if (!abandoned && !found)
                        begin
                            // step to the next entry at the end of this record
                            if (rel >= 7 && rel + 1 == rec_len)
                            begin
                                entry_base += rec_len;
                                names_equal = 1'b1;
                            end
                            offset++;
                        end
                    end
                end
                default: ;
            endcase

            if (name_too_long)
                outcome.status = dens_pkg::ST_TOO_LONG;
            else if (found)
                outcome.status = dens_pkg::ST_FOUND;
            else if (abandoned)
                outcome.status = dens_pkg::ST_ABANDONED;
            else
                outcome.status = dens_pkg::ST_SEARCHING;
            outcome.inode_number = (outcome.status == dens_pkg::ST_FOUND) ? found_inode
                                                                          : 32'd0;
            due_outcomes.push_back(outcome);
        endfunction

        function void check_result(dens_pkg::result_t got);
            dens_pkg::result_t want;
            if (due_outcomes.size() == 0)
            begin
                $error("result word with no item pending: status %0d inode_number %0h",
                       got.status, got.inode_number);
                errors++;
                return;
            end
            want = due_outcomes.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.inode_number !== want.inode_number)
            begin
                $error("inode_number: expected %0h, actual %0h",
                       want.inode_number, got.inode_number);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    dens_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    dens_pkg::result_t result;

    bit            idle_on = 1'b1;
    int unsigned   stall_left = 0;
    lookup_tracker board = new();

    directory_entry_name_search #(
        .NAME_MAX_BYTES  (NAME_MAX_BYTES),
        .BLOCK_MAX_BYTES (BLOCK_MAX_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stall bursts on result_ready while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            result_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Handshake monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                board.note_item(item);
            if (result_valid && result_ready)
                board.check_result(result);
        end
    end

    task automatic send_item(input dens_pkg::item_t w);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // Command word; the fields it does not use carry random values
    task automatic send_ctrl(input logic [1:0] cmd, input logic [7:0] b);
        dens_pkg::item_t w;
        w.command = cmd;
        w.data_byte = b;
        w.first_in_block = 1'($urandom);
        w.block_bytes = 13'($urandom);
        send_item(w);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.due_outcomes.size() != 0) @(posedge clk);
    endtask

    // Append one entry: header, name bytes, then random padding up to span bytes
    function automatic void put_entry(ref logic [7:0] blk[$], input logic [31:0] ino,
                                      input logic [15:0] rec, input logic [7:0] nlen,
                                      input logic [7:0] nm[$], input int unsigned span);
        int unsigned head;
        head = blk.size();
        blk.push_back(ino[7:0]);
        blk.push_back(ino[15:8]);
        blk.push_back(ino[23:16]);
        blk.push_back(ino[31:24]);
        blk.push_back(rec[7:0]);
        blk.push_back(rec[15:8]);
        blk.push_back(nlen);
        blk.push_back(8'($urandom));
        foreach (nm[i])
            blk.push_back(nm[i]);
        while (blk.size() < head + span)
            blk.push_back(8'($urandom));
    endfunction

    // Fill a block of span bytes with entries whose names are near the target;
    // now and then one entry is corrupt and the rest of the block is junk
    function automatic void build_block(ref logic [7:0] blk[$], input logic [7:0] target[$],
                                        input int unsigned span);
        logic [7:0]  nm[$];
        logic [31:0] ino;
        int unsigned room;
        int unsigned rec;
        int unsigned nlen;
        int unsigned idx;
        bit          broken;
        blk.delete();
        broken = 1'b0;
        while (blk.size() < span && !broken)
        begin
            room = span - blk.size();
            nm = target;
            case ($urandom_range(0, 7))
                0: ;
                1:
                begin
                    // one flipped bit
                    if (nm.size() != 0)
                    begin
                        idx = $urandom_range(0, nm.size() - 1);
                        nm[idx] ^= 8'(1 << $urandom_range(0, 7));
                    end
                end
                2: nm.push_back(8'($urandom));
                3: if (nm.size() != 0) void'(nm.pop_back());
                default:
                begin
                    nm.delete();
                    repeat ($urandom_range(0, 12)) nm.push_back(8'($urandom));
                end
            endcase
            ino = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
            rec = (dens_pkg::HDR_BYTES + nm.size() + 3) & ~32'd3;
            if (rec > room)
            begin
                nm.delete();
                rec = room;
            end
            else
            begin
                rec += 4 * $urandom_range(0, 2);
                if (rec > room || room - rec < dens_pkg::HDR_BYTES)
                    rec = room;
            end
            nlen = nm.size();
            if ($urandom_range(0, 11) == 0)
            begin
                broken = 1'b1;
                case ($urandom_range(0, 4))
                    0: rec = $urandom_range(0, dens_pkg::HDR_BYTES - 1);
                    1: rec += $urandom_range(1, 3);
                    2: rec = room + 4 * $urandom_range(1, 4);
                    3: nlen = rec - dens_pkg::HDR_BYTES + $urandom_range(1, 8);
                    default: rec = $urandom_range(0, 65535);
                endcase
            end
            put_entry(blk, ino, 16'(rec), 8'(nlen), nm,
                      broken ? dens_pkg::HDR_BYTES + nm.size() : rec);
        end
        while (blk.size() < span)
            blk.push_back(8'($urandom));
    endfunction

    // Stream a block; wobble swaps in random byte counts on some words
    task automatic stream_block(input logic [7:0] blk[$], input int unsigned limit,
                                input bit wobble);
        dens_pkg::item_t w;
        foreach (blk[i])
        begin
            w.command = dens_pkg::CMD_DIR_BYTE;
            w.data_byte = blk[i];
            w.first_in_block = (i == 0);
            w.block_bytes = (wobble && $urandom_range(0, 2) == 0) ? 13'($urandom)
                                                                   : 13'(limit);
            send_item(w);
        end
    endtask

    // One search: new target name, then one to three directory blocks
    task automatic run_search();
        logic [7:0]  target[$];
        logic [7:0]  blk[$];
        int unsigned span;
        int unsigned limit;
        bit          wobble;
        send_ctrl(dens_pkg::CMD_NEW_SEARCH, 8'($urandom));
        repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10))
        begin
            target.push_back(8'($urandom));
            send_ctrl(dens_pkg::CMD_NAME_BYTE, target[$]);
        end
        repeat ($urandom_range(1, 3))
        begin
            span = 4 * $urandom_range(4, 24);
            build_block(blk, target, span);
            limit = span;
            wobble = 1'b0;
            case ($urandom_range(0, 9))
                6: limit = $urandom_range(0, 1) ? BLOCK_MAX_BYTES : $urandom_range(span, 8191);
                7: limit = $urandom_range(0, span);
                8: wobble = 1'b1;
                9: blk = blk[0 : $urandom_range(0, span - 1)];
                default: ;
            endcase
            stream_block(blk, limit, wobble);
        end
    endtask

    initial
    begin
        logic [7:0]      target[$];
        logic [7:0]      blk[$];
        dens_pkg::item_t w;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unknown command, then a two-byte name of extreme byte values found
        // in a block whose count saturates
        send_ctrl(CMD_NONE, 8'hA5);
        send_ctrl(dens_pkg::CMD_NEW_SEARCH, 8'h00);
        send_ctrl(dens_pkg::CMD_NAME_BYTE, 8'h00);
        send_ctrl(dens_pkg::CMD_NAME_BYTE, 8'hFF);
        target = '{8'h00, 8'hFF};
        put_entry(blk, 32'h0000_0001, 16'd12, 8'd2, target, 12);
        stream_block(blk, 8191, 1'b0);

        // Empty block, then a record length shorter than the header
        send_ctrl(dens_pkg::CMD_NEW_SEARCH, 8'hFF);
        w.command = dens_pkg::CMD_DIR_BYTE;
        w.data_byte = 8'hFF;
        w.first_in_block = 1'b1;
        w.block_bytes = 13'd0;
        send_item(w);
        blk.delete();
        target.delete();
        put_entry(blk, 32'hFFFF_FFFF, 16'd6, 8'd0, target, dens_pkg::HDR_BYTES);
        stream_block(blk, BLOCK_MAX_BYTES, 1'b0);

        // Longest name: full store, full-length entry match, then overflow
        send_ctrl(dens_pkg::CMD_NEW_SEARCH, 8'($urandom));
        repeat (NAME_MAX_BYTES)
        begin
            target.push_back(8'($urandom));
            send_ctrl(dens_pkg::CMD_NAME_BYTE, target[$]);
        end
        blk.delete();
        put_entry(blk, $urandom | 32'd1, 16'(dens_pkg::HDR_BYTES + NAME_MAX_BYTES + 1),
                  8'(NAME_MAX_BYTES), target, dens_pkg::HDR_BYTES + NAME_MAX_BYTES + 1);
        stream_block(blk, dens_pkg::HDR_BYTES + NAME_MAX_BYTES + 1, 1'b0);
        send_ctrl(dens_pkg::CMD_NAME_BYTE, 8'($urandom));
        send_ctrl(dens_pkg::CMD_DIR_BYTE, 8'($urandom));
        send_ctrl(dens_pkg::CMD_NAME_BYTE, 8'($urandom));
        wait_drained();

        // Random searches mixed with raw noise words; no idling near the end
        while (board.seen_words < ITEM_GOAL)
        begin
            if (board.seen_words + 40 >= ITEM_GOAL)
                idle_on = 1'b0;
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 6)) send_item(dens_pkg::item_t'(24'($urandom)));
            else
                run_search();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("directory_entry_name_search_tb: done, clean");
        else
            $display("directory_entry_name_search_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("directory_entry_name_search_tb: done, errors");
        $finish;
    end

endmodule
